// ===== design/hrp_pkg.sv =====
// Shared types, codes and character tables for the HTTP request header parser.
`default_nettype none

package hrp_pkg;

  // Default width of the Content-Length accumulator and body counter.
  localparam int unsigned LENGTH_BITS_DEFAULT = 32;

  // Characters the parser looks for.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Last three path bytes that, followed by a slash, form a parent reference.
  localparam logic [23:0] PARENT_WINDOW = 24'h2F2E2E;

  // Token lengths.
  localparam logic [4:0] GET_LEN   = 5'd3;
  localparam logic [4:0] POST_LEN  = 5'd4;
  localparam logic [4:0] CLEN_LEN  = 5'd14;
  localparam logic [4:0] COUNT_MAX = 5'd31;

  // Byte kinds.
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_PATH    = 3'd1;
  localparam logic [2:0] KIND_VERSION = 3'd2;
  localparam logic [2:0] KIND_HNAME   = 3'd3;
  localparam logic [2:0] KIND_HVALUE  = 3'd4;
  localparam logic [2:0] KIND_BODY    = 3'd5;

  // Events.
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_METHOD_OK = 3'd1;
  localparam logic [2:0] EV_PATH_END  = 3'd2;
  localparam logic [2:0] EV_LINE_END  = 3'd3;
  localparam logic [2:0] EV_NAME_END  = 3'd4;
  localparam logic [2:0] EV_HDR_END   = 3'd5;
  localparam logic [2:0] EV_DONE      = 3'd6;

  // Request status codes.
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_BAD     = 3'd2;
  localparam logic [2:0] ST_NOTIMPL = 3'd3;
  localparam logic [2:0] ST_FORBID  = 3'd4;

  // Parser phases.
  typedef enum logic [7:0] {
    PH_METHOD  = 8'b0000_0001,
    PH_PATH    = 8'b0000_0010,
    PH_VERSION = 8'b0000_0100,
    PH_NEWLINE = 8'b0000_1000,
    PH_HNAME   = 8'b0001_0000,
    PH_HVALUE  = 8'b0010_0000,
    PH_BODY    = 8'b0100_0000,
    PH_HALT    = 8'b1000_0000
  } hrp_phase_t;

  // One input transaction.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_request;
  } hrp_in_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  byte_kind;
    logic [2:0]  event_res;
    logic        method_is_post;
    logic        path_ends_in_slash;
    logic [2:0]  status;
    logic [31:0] body_length;
  } hrp_out_t;

  // Parser control state, apart from the length counters.
  typedef struct packed {
    hrp_phase_t  phase;
    logic [2:0]  status;
    logic        post_method;
    logic [4:0]  token_count;
    logic [1:0]  method_flags;
    logic        length_name_match;
    logic [23:0] path_window;
    logic        path_forbidden;
  } hrp_state_t;

  // Expected character of "GET" at a position.
  function automatic logic [7:0] get_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd0:    ch = 8'h47;
      5'd1:    ch = 8'h45;
      5'd2:    ch = 8'h54;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Expected character of "POST" at a position.
  function automatic logic [7:0] post_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd0:    ch = 8'h50;
      5'd1:    ch = 8'h4F;
      5'd2:    ch = 8'h53;
      5'd3:    ch = 8'h54;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Expected character of "Content-Length" at a position.
  function automatic logic [7:0] clen_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd0:    ch = 8'h43;
      5'd1:    ch = 8'h6F;
      5'd2:    ch = 8'h6E;
      5'd3:    ch = 8'h74;
      5'd4:    ch = 8'h65;
      5'd5:    ch = 8'h6E;
      5'd6:    ch = 8'h74;
      5'd7:    ch = 8'h2D;
      5'd8:    ch = 8'h4C;
      5'd9:    ch = 8'h65;
      5'd10:   ch = 8'h6E;
      5'd11:   ch = 8'h67;
      5'd12:   ch = 8'h74;
      5'd13:   ch = 8'h68;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Reset value of the control state.
  function automatic hrp_state_t state_reset();
    hrp_state_t s;
    s.phase             = PH_METHOD;
    s.status            = ST_BUSY;
    s.post_method       = 1'b0;
    s.token_count       = 5'd0;
    s.method_flags      = 2'b11;
    s.length_name_match = 1'b0;
    s.path_window       = 24'd0;
    s.path_forbidden    = 1'b0;
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/hrp_step.sv =====
// Per-byte next-state and result logic of the HTTP request header parser.
`default_nettype none

module hrp_step
  import hrp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  hrp_state_t             cur_state,
  input  logic [LENGTH_BITS-1:0] cur_len,
  input  logic [LENGTH_BITS-1:0] cur_rem,
  input  hrp_in_t                item,
  output hrp_state_t             nxt_state,
  output logic [LENGTH_BITS-1:0] nxt_len,
  output logic [LENGTH_BITS-1:0] nxt_rem,
  output hrp_out_t               result
);

  localparam int unsigned LW = LENGTH_BITS;

  hrp_state_t    s;
  logic [LW-1:0] len_v;
  logic [LW-1:0] rem_v;
  logic [7:0]    c;
  logic [2:0]    kind;
  logic [2:0]    ev;
  logic          slash;
  logic [LW+3:0] acc;
  logic [LW+3:0] acc_len;
  logic [LW+31:0] len_ext;
  logic          is_digit;
  logic [4:0]    tc_inc;

  assign c        = item.rx_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

  // Decimal accumulate: len * 10 + digit, one wide add; overflow shows above LW bits.
  // The start-of-request reset applies before the byte is looked at.
  assign acc_len = item.new_request ? '0 : {4'b0000, cur_len};
  assign acc     = (acc_len << 3) + (acc_len << 1) + {{LW{1'b0}}, c[3:0]};

  always_comb begin
    if (item.new_request) begin
      s     = state_reset();
      len_v = '0;
      rem_v = '0;
    end else begin
      s     = cur_state;
      len_v = cur_len;
      rem_v = cur_rem;
    end
    kind   = KIND_NONE;
    ev     = EV_NONE;
    slash  = 1'b0;
    tc_inc = (s.token_count < COUNT_MAX) ? s.token_count + 5'd1 : s.token_count;

    // Carriage returns are dropped in every phase.
    if (c != CH_CR) begin
      unique case (s.phase)
        PH_METHOD: begin
          if (c == CH_SP) begin
            if (s.token_count == 5'd0) begin
              s.status = ST_BAD;
              s.phase  = PH_HALT;
            end else if (s.method_flags[0] && s.token_count == GET_LEN) begin
              s.post_method = 1'b0;
              ev            = EV_METHOD_OK;
            end else if (s.method_flags[1] && s.token_count == POST_LEN) begin
              s.post_method = 1'b1;
              ev            = EV_METHOD_OK;
            end else begin
              s.status = ST_NOTIMPL;
              s.phase  = PH_HALT;
            end
            if (ev == EV_METHOD_OK) begin
              s.phase          = PH_PATH;
              s.token_count    = 5'd0;
              s.path_window    = 24'd0;
              s.path_forbidden = 1'b0;
            end
          end else if (c == CH_LF || c == CH_COLON) begin
            s.status = ST_BAD;
            s.phase  = PH_HALT;
          end else begin
            if (s.token_count >= GET_LEN || get_char(s.token_count) != c) begin
              s.method_flags[0] = 1'b0;
            end
            if (s.token_count >= POST_LEN || post_char(s.token_count) != c) begin
              s.method_flags[1] = 1'b0;
            end
            s.token_count = tc_inc;
          end
        end
        PH_PATH: begin
          if (c == CH_SP) begin
            if (s.token_count == 5'd0) begin
              s.status = ST_BAD;
              s.phase  = PH_HALT;
            end else if (s.path_forbidden) begin
              s.status = ST_FORBID;
              s.phase  = PH_HALT;
            end else begin
              ev      = EV_PATH_END;
              slash   = (s.path_window[7:0] == CH_SLASH);
              s.phase = PH_VERSION;
            end
          end else if (c == CH_LF) begin
            s.status = ST_BAD;
            s.phase  = PH_HALT;
          end else begin
            kind = KIND_PATH;
            if (s.path_window == PARENT_WINDOW && c == CH_SLASH) begin
              s.path_forbidden = 1'b1;
            end
            s.path_window = {s.path_window[15:0], c};
            s.token_count = tc_inc;
          end
        end
        PH_VERSION: begin
          if (c == CH_SP) begin
            s.status = ST_BAD;
            s.phase  = PH_HALT;
          end else if (c == CH_LF) begin
            ev      = EV_LINE_END;
            s.phase = PH_NEWLINE;
          end else begin
            kind = KIND_VERSION;
          end
        end
        PH_NEWLINE: begin
          if (c == CH_SP || c == CH_COLON) begin
            s.status = ST_BAD;
            s.phase  = PH_HALT;
          end else if (c == CH_LF) begin
            if (s.post_method && len_v != '0) begin
              rem_v   = len_v;
              s.phase = PH_BODY;
              ev      = EV_HDR_END;
            end else begin
              s.status = ST_DONE;
              s.phase  = PH_HALT;
              ev       = EV_DONE;
            end
          end else begin
            kind                = KIND_HNAME;
            s.phase             = PH_HNAME;
            s.length_name_match = (c == clen_char(5'd0));
            s.token_count       = 5'd1;
          end
        end
        PH_HNAME: begin
          if (c == CH_SP || c == CH_LF) begin
            s.status = ST_BAD;
            s.phase  = PH_HALT;
          end else if (c == CH_COLON) begin
            if (s.length_name_match && s.token_count == CLEN_LEN) begin
              len_v = '0;
            end else begin
              s.length_name_match = 1'b0;
            end
            ev            = EV_NAME_END;
            s.phase       = PH_HVALUE;
            s.token_count = 5'd0;
          end else begin
            kind = KIND_HNAME;
            if (s.token_count >= CLEN_LEN || clen_char(s.token_count) != c) begin
              s.length_name_match = 1'b0;
            end
            s.token_count = tc_inc;
          end
        end
        PH_HVALUE: begin
          if (c == CH_LF) begin
            if (s.token_count == 5'd0) begin
              s.status = ST_BAD;
              s.phase  = PH_HALT;
            end else begin
              s.phase = PH_NEWLINE;
            end
          end else if (c == CH_SP && s.token_count == 5'd0) begin
            // A leading space of the value is skipped.
            kind = KIND_NONE;
          end else begin
            kind          = KIND_HVALUE;
            s.token_count = tc_inc;
            if (s.length_name_match) begin
              if (is_digit) begin
                len_v = (|acc[LW+3:LW]) ? '1 : acc[LW-1:0];
              end else begin
                s.length_name_match = 1'b0;
              end
            end
          end
        end
        PH_BODY: begin
          kind  = KIND_BODY;
          rem_v = rem_v - {{(LW-1){1'b0}}, 1'b1};
          if (rem_v == '0) begin
            s.status = ST_DONE;
            s.phase  = PH_HALT;
            ev       = EV_DONE;
          end
        end
        PH_HALT: begin
          kind = KIND_NONE;
        end
        default: begin
          kind = KIND_NONE;
        end
      endcase
    end
  end

  // The length is shown on 32 bits, saturated when the counter is wider.
  assign len_ext = {32'd0, len_v};

  assign nxt_state = s;
  assign nxt_len   = len_v;
  assign nxt_rem   = rem_v;

  assign result.out_byte           = c;
  assign result.byte_kind          = kind;
  assign result.event_res          = ev;
  assign result.method_is_post     = s.post_method;
  assign result.path_ends_in_slash = slash;
  assign result.status             = s.status;
  assign result.body_length        = (|len_ext[LW+31:32]) ? 32'hFFFF_FFFF : len_ext[31:0];

endmodule

`default_nettype wire

// ===== design/http_request_header_parser.sv =====
// Top level of the HTTP request header parser: state registers and result skid buffer.
//
// Takes one request byte per input transaction and returns exactly one result
// transaction for it, tagging path, version, header and body bytes, flagging
// request events and the request status, and decoding Content-Length on the fly.
// A byte can be accepted every clock cycle while the skid entry is empty, and its
// result is registered. The result side holds an output register plus one skid
// entry, so input is taken while a result waits and stops only once both are
// occupied. The per-byte work is a single pass of phase logic and one decimal
// multiply-add of the length counter, which sets the clock path.
`default_nettype none

module http_request_header_parser
  import hrp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hrp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hrp_out_t out_data
);

  hrp_state_t             state_r, state_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  hrp_out_t               step_res;

  logic     out_valid_r, out_valid_nxt;
  hrp_out_t out_data_r, out_data_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  hrp_out_t skid_data_r, skid_data_nxt;

  logic in_fire;

  hrp_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .cur_state(state_r),
    .cur_len  (len_r),
    .cur_rem  (rem_r),
    .item     (in_data),
    .nxt_state(state_nxt),
    .nxt_len  (len_nxt),
    .nxt_rem  (rem_nxt),
    .result   (step_res)
  );

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;

  // Parser state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= state_reset();
      len_r   <= '0;
      rem_r   <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Output register with one skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      out_valid_nxt  = skid_valid_r || in_fire;
      out_data_nxt   = skid_valid_r ? skid_data_r : step_res;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The skid entry is only ever filled behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // A halted parser always carries a final status.
  a_halt_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_HALT) |-> (state_r.status != ST_BUSY))
    else $error("parser halted with status still in progress");

  // The body phase never runs with nothing left to take.
  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_BODY) |-> (rem_r != '0))
    else $error("body phase with zero bytes remaining");

  // Bytes after the end of a request are not tagged and raise no event.
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && state_r.phase == PH_HALT && !in_data.new_request)
      |-> (step_res.byte_kind == KIND_NONE && step_res.event_res == EV_NONE))
    else $error("halted parser produced a tagged byte or event");

endmodule

`default_nettype wire
